FILE: rtl/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lfra_pkg.sv
// Shared constants for the lowest-free-room allocator.
// No dependencies; imported by the top level, the checker and the testbench.
package lfra_pkg;

  // Default sizing of the room table.
  localparam int NUM_ROOMS_DEF  = 16;
  localparam int COUNT_BITS_DEF = 20;
  localparam int TIME_BITS_DEF  = 48;

  // Fixed field widths of the ports.
  localparam int REQ_W      = 32;
  localparam int CFG_W      = 5;
  localparam int ROOM_W     = 4;
  localparam int OUT_TIME_W = 48;
  localparam int OUT_CNT_W  = 20;
  localparam int STATUS_W   = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ORDER_ERR = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY_ERR = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TIME_SAT  = 2'd3;

endpackage

FILE: rtl/lowest_free_room_allocator.sv
// Lowest-free-room allocator: top level with the scan sequencer and result register.
// Depends on lfra_pkg, lfra_ram and assert_macros.svh.
//
//  Channel  | Direction | Handshake           | Payload
//  ---------+-----------+---------------------+-------------------------------------------
//  in       | input     | in_valid / in_stall | request_start, request_end, new_batch
//  out      | output    | out_valid/out_stall | assigned_room .. busiest_count, status
//  cfg      | input     | cfg_valid/cfg_ready | rooms_in_use
//
// A request goes through an accept step, one room-table read per active room through
// the single RAM read port, a drain step for the last read to return, and an update
// step that writes the room back.
// Reset clears control state and all room valid bits; rooms read as free and unused.
// A stalled result sits in the output register; the next request is still taken,
// and its update cycle waits until the output register is free.
module lowest_free_room_allocator
  import lfra_pkg::*;
#(
  parameter int NUM_ROOMS  = NUM_ROOMS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [REQ_W-1:0]      request_start,
  input  logic [REQ_W-1:0]      request_end,
  input  logic                  new_batch,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ROOM_W-1:0]     assigned_room,
  output logic [OUT_TIME_W-1:0] actual_start,
  output logic [OUT_TIME_W-1:0] actual_end,
  output logic                  was_delayed,
  output logic [ROOM_W-1:0]     busiest_room,
  output logic [OUT_CNT_W-1:0]  busiest_count,
  output logic [STATUS_W-1:0]   status,
  // configuration channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      rooms_in_use
);

`include "assert_macros.svh"

  localparam int RB = (NUM_ROOMS > 1) ? $clog2(NUM_ROOMS) : 1;
  localparam int EW = TIME_BITS + COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [TIME_BITS-1:0]  TIME_MAX  = {TIME_BITS{1'b1}};

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_CALC  = 2'd3;

  logic [1:0]            state;
  logic [CFG_W-1:0]      cfg_rooms;
  logic [REQ_W-1:0]      prev_start;
  logic [REQ_W-1:0]      req_start;
  logic [REQ_W-1:0]      req_end;
  logic [NUM_ROOMS-1:0]  room_valid;

  logic [RB-1:0]         rd_idx;
  logic                  rd_pend;
  logic [RB-1:0]         rd_pend_idx;
  logic                  rd_vld;
  logic [EW-1:0]         rd_data;

  // Scan accumulators.
  logic                  found;
  logic [RB-1:0]         free_idx;
  logic [COUNT_BITS-1:0] free_cnt;
  logic [TIME_BITS-1:0]  min_time;
  logic [RB-1:0]         min_idx;
  logic [COUNT_BITS-1:0] min_cnt;
  logic [RB-1:0]         best_idx;
  logic [COUNT_BITS-1:0] best_cnt;

  logic                  in_accept;
  logic                  load;
  logic [RB-1:0]         last_idx;
  logic [CFG_W-1:0]      cfg_m1;
  logic [TIME_BITS-1:0]  ft;
  logic [COUNT_BITS-1:0] fc;
  logic [TIME_BITS-1:0]  start_ext;

  // Update-cycle values.
  logic                  err_order;
  logic                  err_empty;
  logic                  do_assign;
  logic [RB-1:0]         pick;
  logic [TIME_BITS-1:0]  as_val;
  logic [COUNT_BITS-1:0] cp;
  logic [COUNT_BITS-1:0] cp_next;
  logic [REQ_W-1:0]      dur;
  logic [TIME_BITS:0]    sum;
  logic                  sat;
  logic [TIME_BITS-1:0]  ae_val;
  logic [RB-1:0]         lead_idx;
  logic [COUNT_BITS-1:0] lead_cnt;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign load      = (state == S_CALC) && (!out_valid || !out_stall);
  assign start_ext = TIME_BITS'(req_start);

  // Last active room index: zero acts as one room, large values clamp to the table.
  assign cfg_m1 = cfg_rooms - CFG_W'(1);
  always_comb begin
    if (cfg_rooms == '0) begin
      last_idx = '0;
    end else if (int'(cfg_rooms) >= NUM_ROOMS) begin
      last_idx = RB'(NUM_ROOMS - 1);
    end else begin
      last_idx = RB'(cfg_m1);
    end
  end

  lfra_ram #(
    .WIDTH(EW),
    .DEPTH(NUM_ROOMS)
  ) u_room_ram (
    .clk  (clk),
    .we   (load && do_assign),
    .waddr(pick),
    .wdata({ae_val, cp_next}),
    .raddr(rd_idx),
    .rdata(rd_data)
  );

  // A room never written since reset or the last new batch reads as free and unused.
  assign ft = rd_vld ? rd_data[EW-1:COUNT_BITS] : '0;
  assign fc = rd_vld ? rd_data[COUNT_BITS-1:0] : '0;

  always_comb begin
    err_order = (req_start < prev_start);
    err_empty = (req_end <= req_start);
    do_assign = !err_order && !err_empty;
    pick      = found ? free_idx : min_idx;
    as_val    = found ? start_ext : min_time;
    cp        = found ? free_cnt : min_cnt;
    cp_next   = (cp == COUNT_MAX) ? cp : cp + COUNT_BITS'(1);
    dur       = req_end - req_start;
    sum       = {1'b0, as_val} + (TIME_BITS + 1)'(dur);
    sat       = sum[TIME_BITS];
    ae_val    = sat ? TIME_MAX : sum[TIME_BITS-1:0];
    // Only the picked room's count moves, so the leader is the scanned leader or the pick.
    lead_idx  = best_idx;
    lead_cnt  = best_cnt;
    if (do_assign) begin
      if (pick == best_idx) begin
        lead_cnt = cp_next;
      end else if (cp_next > best_cnt) begin
        lead_idx = pick;
        lead_cnt = cp_next;
      end else if (cp_next == best_cnt && pick < best_idx) begin
        lead_idx = pick;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cfg_rooms  <= CFG_RESET;
      prev_start <= '0;
      room_valid <= '0;
      rd_pend    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_rooms <= rooms_in_use;
      end
      rd_pend <= (state == S_SCAN);
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            if (new_batch) begin
              room_valid <= '0;
              prev_start <= '0;
            end
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_idx == last_idx) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_CALC;
        end
        S_CALC: begin
          if (load) begin
            if (do_assign) begin
              room_valid[pick] <= 1'b1;
              prev_start       <= req_start;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request capture, read sequencing and scan accumulators.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_start <= request_start;
      req_end   <= request_end;
      rd_idx    <= '0;
      found     <= 1'b0;
    end else if (state == S_SCAN && rd_idx != last_idx) begin
      rd_idx <= rd_idx + RB'(1);
    end
    rd_pend_idx <= rd_idx;
    rd_vld      <= room_valid[rd_idx];
    if (rd_pend) begin
      if (!found && ft <= start_ext) begin
        found    <= 1'b1;
        free_idx <= rd_pend_idx;
        free_cnt <= fc;
      end
      if (rd_pend_idx == '0 || ft < min_time) begin
        min_time <= ft;
        min_idx  <= rd_pend_idx;
        min_cnt  <= fc;
      end
      if (rd_pend_idx == '0 || fc > best_cnt) begin
        best_cnt <= fc;
        best_idx <= rd_pend_idx;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (load) begin
      busiest_room  <= ROOM_W'(lead_idx);
      busiest_count <= OUT_CNT_W'(lead_cnt);
      if (do_assign) begin
        assigned_room <= ROOM_W'(pick);
        actual_start  <= OUT_TIME_W'(as_val);
        actual_end    <= OUT_TIME_W'(ae_val);
        was_delayed   <= !found;
        status        <= sat ? ST_TIME_SAT : ST_OK;
      end else begin
        assigned_room <= '0;
        actual_start  <= '0;
        actual_end    <= '0;
        was_delayed   <= 1'b0;
        status        <= err_order ? ST_ORDER_ERR : ST_EMPTY_ERR;
      end
    end
  end

  `ASSERT_IMPL(a_scan_in_range, clk, rst, state == S_SCAN, rd_idx <= last_idx, "scan past active rooms")
  `ASSERT_IMPL(a_delay_later, clk, rst, load && do_assign && !found, min_time > start_ext, "delayed request not later than its start")
  `ASSERT_IMPL(a_leader_count, clk, rst, load && do_assign, lead_cnt >= cp_next, "busiest count below assigned room count")
  `ASSERT_NEXT(a_batch_clear, clk, rst, in_accept && new_batch, room_valid == '0 && prev_start == '0, "new batch did not clear room table")

endmodule

FILE: rtl/lfra_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies; used for the room table of the allocator.
module lfra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: test/lfra_booking_checker.sv
// Checker for the lowest-free-room allocator: watches the request, result and
// configuration channels, predicts every result beat and compares it field by field.
// Depends on lfra_pkg.
`timescale 1ns / 1ps

module lfra_booking_checker
  import lfra_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [REQ_W-1:0]      request_start,
  input  logic [REQ_W-1:0]      request_end,
  input  logic                  new_batch,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [ROOM_W-1:0]     assigned_room,
  input  logic [OUT_TIME_W-1:0] actual_start,
  input  logic [OUT_TIME_W-1:0] actual_end,
  input  logic                  was_delayed,
  input  logic [ROOM_W-1:0]     busiest_room,
  input  logic [OUT_CNT_W-1:0]  busiest_count,
  input  logic [STATUS_W-1:0]   status,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_W-1:0]      rooms_in_use,
  output int                    mismatch_count,
  output int                    pending_results
);

  localparam int ROOMS = NUM_ROOMS_DEF;
  localparam logic [TIME_BITS_DEF-1:0]  TIME_LIMIT  = '1;
  localparam logic [COUNT_BITS_DEF-1:0] COUNT_LIMIT = '1;
  localparam int LOG_CAP = 200;

  typedef struct {
    logic [ROOM_W-1:0]     room;
    logic [OUT_TIME_W-1:0] start_at;
    logic [OUT_TIME_W-1:0] end_at;
    logic                  delayed;
    logic [ROOM_W-1:0]     top_room;
    logic [OUT_CNT_W-1:0]  top_count;
    logic [STATUS_W-1:0]   code;
  } booking_t;

  logic [TIME_BITS_DEF-1:0]  free_at [ROOMS];
  logic [COUNT_BITS_DEF-1:0] uses [ROOMS];
  logic [REQ_W-1:0]          last_start;
  logic [CFG_W-1:0]          room_setting;
  booking_t                  bookings_due [$];
  int                        lines_logged;

  task automatic clear_rooms();
    for (int r = 0; r < ROOMS; r++) begin
      free_at[r] = '0;
      uses[r] = '0;
    end
    last_start = '0;
  endtask

  function automatic int active_rooms();
    if (room_setting == 0) return 1;
    if (room_setting > ROOMS) return ROOMS;
    return int'(room_setting);
  endfunction

  task automatic book_request(input logic [REQ_W-1:0] s, input logic [REQ_W-1:0] e,
                              input logic nb, output booking_t b);
    int act;
    int pick;
    int lead;
    bit found;
    logic [TIME_BITS_DEF-1:0] dur;
    logic [TIME_BITS_DEF-1:0] first;
    logic [TIME_BITS_DEF-1:0] last;
    act = active_rooms();
    b = '{default: '0};
    b.code = ST_OK;
    if (nb) clear_rooms();
    if (s < last_start) begin
      b.code = ST_ORDER_ERR;
    end else if (e <= s) begin
      b.code = ST_EMPTY_ERR;
    end else begin
      dur = TIME_BITS_DEF'(e - s);
      found = 1'b0;
      pick = 0;
      for (int r = 0; r < act; r++) begin
        if (!found && free_at[r] <= TIME_BITS_DEF'(s)) begin
          pick = r;
          found = 1'b1;
        end
      end
      if (found) begin
        first = TIME_BITS_DEF'(s);
      end else begin
        // Every active room is busy: take the earliest to free, lowest index on a tie.
        pick = 0;
        for (int r = 1; r < act; r++)
          if (free_at[r] < free_at[pick]) pick = r;
        first = free_at[pick];
        b.delayed = 1'b1;
      end
      if (dur > TIME_LIMIT - first) begin
        last = TIME_LIMIT;
        b.code = ST_TIME_SAT;
      end else begin
        last = first + dur;
      end
      free_at[pick] = last;
      if (uses[pick] != COUNT_LIMIT) uses[pick] = uses[pick] + 1'b1;
      last_start = s;
      b.room = ROOM_W'(pick);
      b.start_at = first;
      b.end_at = last;
    end
    lead = 0;
    for (int r = 1; r < act; r++)
      if (uses[r] > uses[lead]) lead = r;
    b.top_room = ROOM_W'(lead);
    b.top_count = uses[lead];
  endtask

  task automatic check_field(input string label, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      // The log is capped; the count keeps going.
      if (lines_logged < LOG_CAP)
        $display("%0t ns: %s expected %0h, got %0h", $time, label, want, got);
      lines_logged++;
    end
  endtask

  always @(posedge clk) begin : watch
    booking_t want;
    booking_t fresh;
    if (rst) begin
      clear_rooms();
      room_setting = CFG_RESET;
      bookings_due.delete();
      mismatch_count = 0;
      pending_results = 0;
      lines_logged = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (bookings_due.size() == 0) begin
          mismatch_count++;
          if (lines_logged < LOG_CAP)
            $display("%0t ns: result beat expected none, got room %0h status %0h",
                     $time, assigned_room, status);
          lines_logged++;
        end else begin
          want = bookings_due.pop_front();
          check_field("assigned_room", 64'(want.room), 64'(assigned_room));
          check_field("actual_start", 64'(want.start_at), 64'(actual_start));
          check_field("actual_end", 64'(want.end_at), 64'(actual_end));
          check_field("was_delayed", 64'(want.delayed), 64'(was_delayed));
          check_field("busiest_room", 64'(want.top_room), 64'(busiest_room));
          check_field("busiest_count", 64'(want.top_count), 64'(busiest_count));
          check_field("status", 64'(want.code), 64'(status));
        end
      end
      if (cfg_valid && cfg_ready) room_setting = rooms_in_use;
      if (in_valid && !in_stall) begin
        book_request(request_start, request_end, new_batch, fresh);
        bookings_due.push_back(fresh);
      end
      pending_results = bookings_due.size();
    end
  end

endmodule

FILE: test/tb_lowest_free_room_allocator.sv
// Testbench top for the lowest-free-room allocator: clock, reset, request and
// configuration stimulus, result-side stalls and the verdict.
// Depends on lfra_pkg, the allocator RTL and lfra_booking_checker.
`timescale 1ns / 1ps

module tb_lowest_free_room_allocator;
  import lfra_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;
  localparam int TAIL_REQUESTS = 24;
  localparam logic [REQ_W-1:0] TICK_MAX = '1;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [REQ_W-1:0]      request_start = '0;
  logic [REQ_W-1:0]      request_end = '0;
  logic                  new_batch = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [ROOM_W-1:0]     assigned_room;
  logic [OUT_TIME_W-1:0] actual_start;
  logic [OUT_TIME_W-1:0] actual_end;
  logic                  was_delayed;
  logic [ROOM_W-1:0]     busiest_room;
  logic [OUT_CNT_W-1:0]  busiest_count;
  logic [STATUS_W-1:0]   status;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      rooms_in_use = CFG_RESET;
  int                    mismatch_count;
  int                    pending_results;
  bit                    gaps_on = 1'b0;
  int                    idle_cycles = 0;
  int                    burst_left = 0;

  always #2 clk = ~clk;

  lowest_free_room_allocator dut (.*);

  lfra_booking_checker booking_check (.*);

  // Random result-side stall bursts, started only while gaps are on.
  always @(negedge clk) begin
    if (burst_left == 0 && gaps_on && $urandom_range(0, 4) == 0)
      burst_left = $urandom_range(1, 3);
    out_stall <= (burst_left != 0);
    if (burst_left != 0) burst_left--;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic offer_request(input logic [REQ_W-1:0] s, input logic [REQ_W-1:0] e,
                               input logic nb);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    request_start <= s;
    request_end <= e;
    new_batch <= nb;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  task automatic set_room_count(input logic [CFG_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    rooms_in_use <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Batches of meetings in start order with random content, salted with refused
  // starts, empty meetings and stray batch clears.
  task automatic book_random_meetings(input int count, input logic [CFG_W-1:0] setting,
                                      input bit quiet);
    int left;
    int batch_left;
    int kind;
    bit wide;
    logic [REQ_W-1:0] cursor;
    logic [REQ_W-1:0] s;
    logic [REQ_W-1:0] e;
    logic [REQ_W-1:0] dur;
    logic [REQ_W:0] sum;
    logic nb;
    set_room_count(setting);
    left = count;
    batch_left = 0;
    wide = 1'b0;
    cursor = '0;
    while (left > 0) begin
      nb = 1'b0;
      if (batch_left == 0) begin
        batch_left = $urandom_range(6, 40);
        wide = ($urandom_range(0, 3) == 0);
        gaps_on = !quiet && ($urandom_range(0, 4) != 0);
        nb = 1'b1;
        cursor = wide ? REQ_W'($urandom) : '0;
      end
      kind = $urandom_range(0, 19);
      if (kind == 0 && !nb) begin
        nb = 1'b1;
        cursor = '0;
      end
      sum = {1'b0, cursor} + (REQ_W + 1)'(wide ? $urandom_range(0, 32'h00FF_FFFF)
                                                : $urandom_range(0, 3));
      s = sum[REQ_W] ? TICK_MAX : sum[REQ_W-1:0];
      if (kind == 1 && !nb && cursor != 0) begin
        s = $urandom_range(0, cursor - 1);
        e = $urandom;
      end else if (kind == 2) begin
        e = $urandom_range(0, s);
      end else begin
        if (!wide)
          dur = $urandom_range(1, 72);
        else if ($urandom_range(0, 3) == 0)
          dur = $urandom;
        else
          dur = $urandom_range(1, 32'h0FFF_FFFF);
        sum = {1'b0, s} + {1'b0, dur};
        e = sum[REQ_W] ? TICK_MAX : sum[REQ_W-1:0];
        if (e > s) cursor = s;
      end
      offer_request(s, e, nb);
      left--;
      batch_left--;
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    gaps_on = 1'b1;

    // Sixteen rooms from reset: smallest and widest meetings.
    offer_request(0, 1, 1'b1);
    offer_request(0, TICK_MAX, 1'b0);
    offer_request(100, 200, 1'b0);
    // A start behind the last booked one is refused, also when it is empty as well.
    offer_request(50, 60, 1'b0);
    offer_request(50, 40, 1'b0);
    offer_request(200, 200, 1'b0);
    offer_request(300, 250, 1'b0);
    offer_request(TICK_MAX - 1, TICK_MAX, 1'b0);
    offer_request(TICK_MAX, TICK_MAX, 1'b0);
    // The batch clear also resets the order check.
    offer_request(TICK_MAX, 0, 1'b1);
    offer_request(7, 9, 1'b1);

    // Two rooms: a tie on the earliest free time, then a room free exactly at the start.
    set_room_count(2);
    offer_request(10, 20, 1'b1);
    offer_request(10, 20, 1'b0);
    offer_request(10, 15, 1'b0);
    offer_request(12, 30, 1'b0);
    offer_request(25, 26, 1'b0);

    // A room count of zero acts as one room; above the table size acts as all rooms.
    set_room_count(0);
    offer_request(0, 10, 1'b1);
    offer_request(5, 6, 1'b0);
    offer_request(5, 6, 1'b0);
    set_room_count(31);
    offer_request(3, 4, 1'b1);
    offer_request(3, 4, 1'b0);

    book_random_meetings(90, 5'd16, 1'b0);
    book_random_meetings(90, 5'd1, 1'b0);
    book_random_meetings(90, 5'd2, 1'b0);
    book_random_meetings(90, 5'd5, 1'b0);
    book_random_meetings(90, CFG_W'($urandom_range(3, 15)), 1'b0);
    book_random_meetings(90, 5'd0, 1'b0);
    book_random_meetings(90, 5'd31, 1'b0);
    book_random_meetings(90, 5'd17, 1'b0);
    book_random_meetings(90, 5'd8, 1'b1);
    book_random_meetings(90, 5'd16, 1'b1);

    // One room and back-to-back full-width meetings: each one queues behind the last,
    // so the free time climbs far past the 32-bit start range.
    set_room_count(1);
    gaps_on = 1'b0;
    offer_request(0, TICK_MAX, 1'b1);
    repeat (TAIL_REQUESTS) offer_request(0, TICK_MAX, 1'b0);
    offer_request(1, 2, 1'b0);
    offer_request(0, 5, 1'b0);

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
